// File: hw/rtl/hrd_pkg.sv
// Shared types and constants of the HTTP response header deframer.
`default_nettype none

package hrd_pkg;

	localparam int CL_WIDTH  = 40;
	localparam int TOKEN_LEN = 16;
	localparam int TOKEN_PW  = 4;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;

	// "Content-Length: "
	localparam logic [7:0] TOKEN_TEXT [TOKEN_LEN] = '{
		8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
		8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
	};

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	localparam logic [1:0] DP_IDLE   = 2'd0;
	localparam logic [1:0] DP_FIRST  = 2'd1;
	localparam logic [1:0] DP_DIGITS = 2'd2;
	localparam logic [1:0] DP_LF     = 2'd3;

	localparam logic [1:0] TM_NONE   = 2'd0;
	localparam logic [1:0] TM_CR     = 2'd1;
	localparam logic [1:0] TM_CRLF   = 2'd2;
	localparam logic [1:0] TM_CRLFCR = 2'd3;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_NO_LENGTH  = 2'd1;
	localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic                body_valid;
		logic [7:0]          body_byte;
		logic                body_last;
		logic                header_done;
		logic                length_known;
		logic [CL_WIDTH-1:0] content_length;
		logic [1:0]          error_code;
	} out_item_t;

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 first_byte;
		logic                 is_cr;
		logic                 is_lf;
		logic                 is_digit;
		logic [3:0]           digit;
		logic [TOKEN_LEN-1:0] tok_hit;
	} cls_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/hrd_ifs.sv
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none

interface hrd_byte_if;
	import hrd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface hrd_result_if;
	import hrd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hrd_front.sv
// Front end: accepts bytes and registers them with their character class.
`default_nettype none

module hrd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	hrd_byte_if.sink               byte_in,
	output hrd_pkg::cls_item_t     item,
	output logic                   item_valid,
	input  wire logic              item_ready
);
	import hrd_pkg::*;

	cls_item_t cls_d;
	cls_item_t cls_s1;
	logic      valid_s1;
	logic      take;

	always_comb begin
		cls_d.data_byte  = byte_in.payload.data_byte;
		cls_d.first_byte = byte_in.payload.first_byte;
		cls_d.is_cr      = (byte_in.payload.data_byte == CH_CR);
		cls_d.is_lf      = (byte_in.payload.data_byte == CH_LF);
		cls_d.is_digit   = (byte_in.payload.data_byte >= CH_0) &&
		                   (byte_in.payload.data_byte <= CH_9);
		cls_d.digit      = byte_in.payload.data_byte[3:0];
		for (int i = 0; i < TOKEN_LEN; i++) begin
			cls_d.tok_hit[i] = (byte_in.payload.data_byte == TOKEN_TEXT[i]);
		end
	end

	assign byte_in.ready = !valid_s1 || item_ready;
	assign take          = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls_d;
		end
	end

	assign item       = cls_s1;
	assign item_valid = valid_s1;

endmodule

`default_nettype wire

// File: hw/rtl/hrd_queue.sv
// Two-entry queue of classified bytes between the front and back ends.
`default_nettype none

module hrd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hrd_pkg::cls_item_t push_item,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output hrd_pkg::cls_item_t     pop_item,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);
	import hrd_pkg::*;

	cls_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/hrd_back.sv
// Back end: header/body state machine and the registered result stage.
`default_nettype none

module hrd_back #(
	parameter int LENGTH_BITS = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hrd_pkg::cls_item_t item,
	input  wire logic              item_valid,
	output logic                   item_ready,
	hrd_result_if.source           result_out
);
	import hrd_pkg::*;

	localparam int LB = LENGTH_BITS;
	localparam int WB = (LENGTH_BITS > CL_WIDTH) ? LENGTH_BITS : CL_WIDTH;

	logic [1:0]          phase_q;
	logic [TOKEN_PW-1:0] tok_pos_q;
	logic [1:0]          term_pos_q;
	logic [1:0]          dig_phase_q;
	logic [LB-1:0]       acc_q;
	logic [LB-1:0]       len_q;
	logic                len_valid_q;
	logic [LB-1:0]       body_cnt_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic                take;
	logic [1:0]          ph_c, ph_n;
	logic [TOKEN_PW-1:0] tp_c, tp_n;
	logic [1:0]          tm_c, tm_n;
	logic [1:0]          dp_c, dp_n;
	logic [LB-1:0]       acc_c, acc_n;
	logic [LB-1:0]       len_c, len_n;
	logic                lv_c, lv_n;
	logic [LB-1:0]       bc_c, bc_n;
	logic [LB+3:0]       prod;
	logic [1:0]          err;
	logic                hdone;
	logic                bvalid;
	logic                blast;
	logic [WB-1:0]       len_ext;
	out_item_t           out_d;

	assign item_ready = !out_valid_q || result_out.ready;
	assign take       = item_valid && item_ready;

	// A first-byte mark starts from the reset state.
	always_comb begin
		ph_c  = item.first_byte ? PH_HEADER : phase_q;
		tp_c  = item.first_byte ? '0 : tok_pos_q;
		tm_c  = item.first_byte ? TM_NONE : term_pos_q;
		dp_c  = item.first_byte ? DP_IDLE : dig_phase_q;
		acc_c = item.first_byte ? '0 : acc_q;
		len_c = item.first_byte ? '0 : len_q;
		lv_c  = item.first_byte ? 1'b0 : len_valid_q;
		bc_c  = item.first_byte ? '0 : body_cnt_q;
	end

	always_comb begin
		ph_n   = ph_c;
		tp_n   = tp_c;
		tm_n   = tm_c;
		dp_n   = dp_c;
		acc_n  = acc_c;
		len_n  = len_c;
		lv_n   = lv_c;
		bc_n   = bc_c;
		err    = ERR_NONE;
		hdone  = 1'b0;
		bvalid = 1'b0;
		blast  = 1'b0;
		// acc * 10 + digit, with four guard bits to spot overflow
		prod   = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0} +
		         {{LB{1'b0}}, item.digit};

		unique case (ph_c)
			PH_HEADER: begin
				unique case (dp_c)
					DP_IDLE: begin
						if (!lv_c) begin
							if (item.tok_hit[tp_c]) begin
								if (tp_c == TOKEN_PW'(TOKEN_LEN - 1)) begin
									tp_n  = '0;
									dp_n  = DP_FIRST;
									acc_n = '0;
								end else begin
									tp_n = tp_c + 1'b1;
								end
							end else begin
								tp_n = item.tok_hit[0] ? TOKEN_PW'(1) : '0;
							end
						end
					end
					DP_FIRST, DP_DIGITS: begin
						priority if (item.is_digit) begin
							if (prod[LB+3:LB] != 4'd0) begin
								err = ERR_BAD_LENGTH;
							end else begin
								acc_n = prod[LB-1:0];
								dp_n  = DP_DIGITS;
							end
						end else if (dp_c == DP_DIGITS && item.is_cr) begin
							dp_n = DP_LF;
						end else begin
							err = ERR_BAD_LENGTH;
						end
					end
					DP_LF: begin
						if (item.is_lf) begin
							len_n = acc_c;
							lv_n  = 1'b1;
							dp_n  = DP_IDLE;
						end else begin
							err = ERR_BAD_LENGTH;
						end
					end
				endcase

				if (err != ERR_NONE) begin
					ph_n = PH_ERROR;
				end else begin
					priority if (item.is_cr) begin
						tm_n = (tm_c == TM_CRLF) ? TM_CRLFCR : TM_CR;
					end else if (item.is_lf && tm_c == TM_CR) begin
						tm_n = TM_CRLF;
					end else if (item.is_lf && tm_c == TM_CRLFCR) begin
						tm_n  = TM_NONE;
						hdone = 1'b1;
						if (!lv_n || len_n == '0) begin
							err  = ERR_NO_LENGTH;
							ph_n = PH_ERROR;
						end else begin
							ph_n = PH_BODY;
							bc_n = '0;
						end
					end else begin
						tm_n = TM_NONE;
					end
				end
			end
			PH_BODY: begin
				bvalid = 1'b1;
				bc_n   = bc_c + 1'b1;
				if (bc_n == len_c) begin
					blast = 1'b1;
					ph_n  = PH_DONE;
				end
			end
			PH_DONE, PH_ERROR: begin
				// drop the byte
			end
		endcase
	end

	always_comb begin
		len_ext              = WB'(len_n);
		out_d.body_valid     = bvalid;
		out_d.body_byte      = bvalid ? item.data_byte : 8'h00;
		out_d.body_last      = blast;
		out_d.header_done    = hdone;
		out_d.length_known   = lv_n;
		out_d.content_length = len_ext[CL_WIDTH-1:0];
		out_d.error_code     = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			tok_pos_q   <= '0;
			term_pos_q  <= TM_NONE;
			dig_phase_q <= DP_IDLE;
			acc_q       <= '0;
			len_q       <= '0;
			len_valid_q <= 1'b0;
			body_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q     <= ph_n;
				tok_pos_q   <= tp_n;
				term_pos_q  <= tm_n;
				dig_phase_q <= dp_n;
				acc_q       <= acc_n;
				len_q       <= len_n;
				len_valid_q <= lv_n;
				body_cnt_q  <= bc_n;
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q <= out_d;
		end
	end

	assign result_out.valid   = out_valid_q;
	assign result_out.payload = out_item_q;

endmodule

`default_nettype wire

// File: hw/rtl/http_response_header_deframer.sv
// HTTP response deframer: parses Content-Length and passes the body through.
//
// byte_in carries one response byte and a first-byte mark per transfer;
// a set mark clears all parsing state before that byte is handled.
// result_out carries exactly one result per input byte: the body byte with
// its valid and last flags, the header-done flag, the committed length and
// an error code that appears only on the byte that detects the error.
// After the body or an error, results still come but carry no body byte.
// Throughput is one byte per clock while result_out does not stall: the
// state machine in the back end updates all parser state for each byte.
// An input transfer reaches its result through the classify register,
// the queue and the result register.
// A stall on result_out holds the result register; the two-entry queue and
// the front register absorb bytes until byte_in.ready drops, and input is
// taken again in the cycle after the receiver resumes.
// arst_n clears the queue, all valid flags and the parser to the header
// phase with no length committed.
`default_nettype none

module http_response_header_deframer #(
	parameter int LENGTH_BITS = 40
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hrd_byte_if.sink     byte_in,
	hrd_result_if.source result_out
);
	import hrd_pkg::*;

	cls_item_t front_item;
	logic      front_valid;
	logic      front_ready;
	cls_item_t back_item;
	logic      back_valid;
	logic      back_ready;

	hrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	hrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_item   (back_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	hrd_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_valid (back_valid),
		.item_ready (back_ready),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

// File: hw/rtl/hrd_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
`default_nettype none

module hrd_port_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire hrd_pkg::out_item_t out_item
);
	import hrd_pkg::*;

	a_last_is_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.body_last |-> out_item.body_valid)
		else $error("body_last without body_valid");

	a_hdr_not_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.header_done |-> !out_item.body_valid)
		else $error("header_done on a body byte");

	a_no_len_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error_code == ERR_NO_LENGTH |-> out_item.header_done)
		else $error("missing-length error away from the header end");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

endmodule

bind http_response_header_deframer hrd_port_checker u_hrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_item  (result_out.payload)
);

`default_nettype wire
